// ----- rtl/trpm_pkg.sv -----
// ----------------------------------------------------------------------------
// trpm_pkg
// Shared types and codes of the touch report parser and mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package trpm_pkg;

  // result kinds
  typedef enum logic [2:0] {
    KIND_POINT     = 3'd0,
    KIND_DONE      = 3'd1,
    KIND_NOT_READY = 3'd2,
    KIND_NO_TOUCH  = 3'd3,
    KIND_MALFORMED = 3'd4
  } kind_t;

  // configuration register indexes
  localparam logic [2:0] REG_ROTATION    = 3'd0;
  localparam logic [2:0] REG_SWAP_XY     = 3'd1;
  localparam logic [2:0] REG_INVERT_X    = 3'd2;
  localparam logic [2:0] REG_INVERT_Y    = 3'd3;
  localparam logic [2:0] REG_SPAN_X      = 3'd4;
  localparam logic [2:0] REG_SPAN_Y      = 3'd5;
  localparam logic [2:0] REG_AREA_WIDTH  = 3'd6;
  localparam logic [2:0] REG_AREA_HEIGHT = 3'd7;

  localparam int STATUS_READY_BIT = 7;
  localparam int COUNT_W          = 4;
  localparam int TOTAL_W          = 3;

  localparam logic [15:0] SPAN_X_RESET = 16'd960;
  localparam logic [15:0] SPAN_Y_RESET = 16'd540;
  localparam logic [15:0] AREA_W_RESET = 16'd960;
  localparam logic [15:0] AREA_H_RESET = 16'd540;

  typedef struct packed {
    logic [1:0]  rotation;
    logic        swap_xy;
    logic        invert_x;
    logic        invert_y;
    logic [15:0] span_x;
    logic [15:0] span_y;
    logic [15:0] area_width;
    logic [15:0] area_height;
  } cfg_t;

  // one parsed event handed from the byte parser to the mapper
  typedef struct packed {
    logic               valid;
    logic               restart;
    logic               status;
    kind_t              status_kind;
    logic               status_clear;
    logic               record;
    logic               done;
    logic [7:0]         id;
    logic [15:0]        x;
    logic [15:0]        y;
    logic [TOTAL_W-1:0] raw_total;
  } ev_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         touch_id;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [TOTAL_W-1:0] valid_count;
    logic [TOTAL_W-1:0] raw_count;
    logic               clear_status;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/touch_report_parse_and_map.sv -----
// ----------------------------------------------------------------------------
// touch_report_parse_and_map
// Parses touch controller point reports and maps points to display space.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries the bytes of one controller read, one byte per transaction;
//   s_tuser is high on the status byte that opens a frame. m_* carries the
//   results: points, then a frame summary with m_tlast high, or a single
//   not ready / no touch / malformed result. cfg_* writes the mapping
//   registers and is always ready; write it only while the block is idle.
//   Path: the parser loads the event register from the accepted byte,
//   the mapper forms the result from it and writes the result queue, and
//   m_tvalid shows the queue head.
//   Throughput: one byte per cycle, bounded by the eight-entry result
//   queue: s_tready drops while the queue plus the event in flight could
//   overflow, so a stalled receiver stops the input without losing any
//   result. A byte closing a record may produce two results,
//   a point and the summary.
//   Reset: the parser waits for a status byte, the queue is empty, the
//   mapping registers take their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_report_parse_and_map #(
  parameter int MAX_POINTS   = 5,
  parameter int RECORD_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // data_byte
  input  wire logic        s_tuser,    // frame_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,    // touch_id, pos_x, pos_y, valid_count,
                                       // raw_count, clear_status, zero fill
  output logic [2:0]       m_tuser,    // kind
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int OUT_DEPTH = 8;
  localparam int CW        = $clog2(OUT_DEPTH) + 1;

  trpm_pkg::cfg_t cfg;
  trpm_pkg::ev_t  ev;
  trpm_pkg::res_t res0, res1, q;
  logic [1:0]     push_cnt;
  logic [CW-1:0]  count;
  logic           in_accept, pop;

  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign pop       = m_tvalid && m_tready;
  // room for the event in flight and for the one this byte makes
  assign s_tready  = ({1'b0, count} + (ev.valid ? (CW+1)'(2) : (CW+1)'(0)))
                     <= (CW+1)'(OUT_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation    <= 2'd0;
      cfg.swap_xy     <= 1'b0;
      cfg.invert_x    <= 1'b0;
      cfg.invert_y    <= 1'b0;
      cfg.span_x      <= trpm_pkg::SPAN_X_RESET;
      cfg.span_y      <= trpm_pkg::SPAN_Y_RESET;
      cfg.area_width  <= trpm_pkg::AREA_W_RESET;
      cfg.area_height <= trpm_pkg::AREA_H_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        trpm_pkg::REG_ROTATION:    cfg.rotation    <= cfg_data[1:0];
        trpm_pkg::REG_SWAP_XY:     cfg.swap_xy     <= cfg_data[0];
        trpm_pkg::REG_INVERT_X:    cfg.invert_x    <= cfg_data[0];
        trpm_pkg::REG_INVERT_Y:    cfg.invert_y    <= cfg_data[0];
        trpm_pkg::REG_SPAN_X:      cfg.span_x      <= cfg_data;
        trpm_pkg::REG_SPAN_Y:      cfg.span_y      <= cfg_data;
        trpm_pkg::REG_AREA_WIDTH:  cfg.area_width  <= cfg_data;
        trpm_pkg::REG_AREA_HEIGHT: cfg.area_height <= cfg_data;
      endcase
    end
  end

  trpm_parse #(
    .MAX_POINTS   (MAX_POINTS),
    .RECORD_BYTES (RECORD_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .in_accept   (in_accept),
    .data_byte   (s_tdata),
    .frame_start (s_tuser),
    .ev          (ev)
  );

  trpm_map u_map (
    .clk      (clk),
    .rst      (rst),
    .ev       (ev),
    .cfg      (cfg),
    .push_cnt (push_cnt),
    .res0     (res0),
    .res1     (res1)
  );

  trpm_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (push_cnt),
    .din0     (res0),
    .din1     (res1),
    .pop      (pop),
    .dout     (q),
    .count    (count)
  );

  assign m_tvalid = (count != '0);
  assign m_tdata  = {1'b0, q.clear_status, q.raw_count, q.valid_count,
                     q.pos_y, q.pos_x, q.touch_id};
  assign m_tuser  = q.kind;
  assign m_tlast  = q.last;

  // the queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, count} + (CW+1)'(push_cnt) - (CW+1)'(pop)) <= (CW+1)'(OUT_DEPTH))
    else $error("result queue overflow");

  // every accepted status byte becomes a restart event
  a_start_event: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tuser) |=> (ev.valid && ev.restart))
    else $error("status byte did not restart the frame");

  // a point result never closes a frame
  a_point_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == trpm_pkg::KIND_POINT)) |-> !m_tlast)
    else $error("point result marked last");

  // two results only come from a closing record
  a_two_results: assert property (@(posedge clk) disable iff (rst)
    (push_cnt == 2'd2) |-> (ev.valid && ev.record && ev.done))
    else $error("double push without a closing record");

endmodule

`default_nettype wire

// ----- rtl/trpm_parse.sv -----
// ----------------------------------------------------------------------------
// trpm_parse
// Byte level parser: status byte decode, record assembly, event register.
// ----------------------------------------------------------------------------
`default_nettype none

module trpm_parse #(
  parameter int MAX_POINTS   = 5,
  parameter int RECORD_BYTES = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_accept,
  input  wire logic [7:0]     data_byte,
  input  wire logic           frame_start,
  output trpm_pkg::ev_t       ev
);

  localparam int LEFT_W = $clog2(MAX_POINTS + 1);
  localparam int POS_W  = $clog2(RECORD_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(RECORD_BYTES - 1);

  typedef enum logic [1:0] {
    ST_STATUS = 2'b01,
    ST_RECORD = 2'b10
  } state_t;

  state_t state, state_next;
  logic [LEFT_W-1:0] records_left, records_left_next;
  logic [POS_W-1:0]  byte_pos, byte_pos_next;
  logic [7:0]        held_id, held_id_next;
  logic [15:0]       held_x, held_x_next;
  logic [15:0]       held_y, held_y_next;
  logic [trpm_pkg::TOTAL_W-1:0] raw_total, raw_total_next;
  trpm_pkg::ev_t     ev_next;
  logic [trpm_pkg::COUNT_W-1:0] count;

  assign count = data_byte[trpm_pkg::COUNT_W-1:0];

  always_comb begin
    state_next        = state;
    records_left_next = records_left;
    byte_pos_next     = byte_pos;
    held_id_next      = held_id;
    held_x_next       = held_x;
    held_y_next       = held_y;
    raw_total_next    = raw_total;
    ev_next           = '0;
    ev_next.status_kind = trpm_pkg::KIND_NOT_READY;
    if (in_accept) begin
      if (frame_start) begin
        state_next        = ST_STATUS;
        records_left_next = '0;
        byte_pos_next     = '0;
        raw_total_next    = '0;
        ev_next.valid     = 1'b1;
        ev_next.restart   = 1'b1;
        if (!data_byte[trpm_pkg::STATUS_READY_BIT]) begin
          ev_next.status      = 1'b1;
          ev_next.status_kind = trpm_pkg::KIND_NOT_READY;
        end else if (count == '0) begin
          ev_next.status       = 1'b1;
          ev_next.status_kind  = trpm_pkg::KIND_NO_TOUCH;
          ev_next.status_clear = 1'b1;
        end else if (32'(count) > MAX_POINTS) begin
          ev_next.status       = 1'b1;
          ev_next.status_kind  = trpm_pkg::KIND_MALFORMED;
          ev_next.status_clear = 1'b1;
        end else begin
          state_next        = ST_RECORD;
          records_left_next = LEFT_W'(count);
        end
      end else if (state == ST_RECORD) begin
        unique case (byte_pos)
          POS_W'(0): held_id_next = data_byte;
          POS_W'(1): held_x_next  = {held_x[15:8], data_byte};
          POS_W'(2): held_x_next  = {data_byte, held_x[7:0]};
          POS_W'(3): held_y_next  = {held_y[15:8], data_byte};
          POS_W'(4): held_y_next  = {data_byte, held_y[7:0]};
          default: ;
        endcase
        if (byte_pos == LAST_POS) begin
          byte_pos_next     = '0;
          raw_total_next    = raw_total + 1'b1;
          records_left_next = records_left - 1'b1;
          ev_next.valid     = 1'b1;
          ev_next.record    = 1'b1;
          ev_next.id        = held_id_next;
          ev_next.x         = held_x_next;
          ev_next.y         = held_y_next;
          ev_next.raw_total = raw_total_next;
          // final record of the frame closes it
          if (records_left == LEFT_W'(1)) begin
            ev_next.done = 1'b1;
            state_next   = ST_STATUS;
          end
        end else begin
          byte_pos_next = byte_pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_STATUS;
      records_left <= '0;
      byte_pos     <= '0;
      raw_total    <= '0;
      ev.valid     <= 1'b0;
    end else begin
      state        <= state_next;
      records_left <= records_left_next;
      byte_pos     <= byte_pos_next;
      raw_total    <= raw_total_next;
      ev.valid     <= ev_next.valid;
    end
    // record bytes and event payload need no reset
    held_id          <= held_id_next;
    held_x           <= held_x_next;
    held_y           <= held_y_next;
    ev.restart       <= ev_next.restart;
    ev.status        <= ev_next.status;
    ev.status_kind   <= ev_next.status_kind;
    ev.status_clear  <= ev_next.status_clear;
    ev.record        <= ev_next.record;
    ev.done          <= ev_next.done;
    ev.id            <= ev_next.id;
    ev.x             <= ev_next.x;
    ev.y             <= ev_next.y;
    ev.raw_total     <= ev_next.raw_total;
  end

endmodule

`default_nettype wire

// ----- rtl/trpm_map.sv -----
// ----------------------------------------------------------------------------
// trpm_map
// Coordinate mapping, area check, frame valid count and result forming.
// ----------------------------------------------------------------------------
`default_nettype none

module trpm_map (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire trpm_pkg::ev_t  ev,
  input  wire trpm_pkg::cfg_t cfg,
  output logic [1:0]         push_cnt,
  output trpm_pkg::res_t     res0,
  output trpm_pkg::res_t     res1
);

  logic [15:0] a, b, sa, sb;
  logic signed [17:0] a_s, b_s, na, nb;
  logic signed [17:0] a_inv, b_inv, a_neg, b_neg;
  logic signed [17:0] mx, my;
  logic inv_a, inv_b, point_ok;
  logic [trpm_pkg::TOTAL_W-1:0] valid_total, valid_total_next;
  trpm_pkg::res_t point_res, done_res, status_res;

  always_comb begin
    a  = cfg.swap_xy ? ev.y : ev.x;
    b  = cfg.swap_xy ? ev.x : ev.y;
    sa = cfg.swap_xy ? cfg.span_y : cfg.span_x;
    sb = cfg.swap_xy ? cfg.span_x : cfg.span_y;
    a_s = $signed({2'b00, a});
    b_s = $signed({2'b00, b});
    na  = $signed({2'b00, sa}) - 18'sd1 - a_s;
    nb  = $signed({2'b00, sb}) - 18'sd1 - b_s;
    inv_a = cfg.invert_x && (sa != 16'd0);
    inv_b = cfg.invert_y && (sb != 16'd0);
    // after invert, and span-1 minus the inverted value, which undoes it
    a_inv = inv_a ? na : a_s;
    a_neg = inv_a ? a_s : na;
    b_inv = inv_b ? nb : b_s;
    b_neg = inv_b ? b_s : nb;
    unique case (cfg.rotation)
      2'd1: begin mx = b_neg; my = a_inv; end
      2'd2: begin mx = a_neg; my = b_neg; end
      2'd3: begin mx = b_inv; my = a_neg; end
      default: begin mx = a_inv; my = b_inv; end
    endcase
    point_ok = !mx[17] && !my[17]
               && (mx < $signed({2'b00, cfg.area_width}))
               && (my < $signed({2'b00, cfg.area_height}));
  end

  always_comb begin
    if (ev.valid && ev.restart) begin
      valid_total_next = '0;
    end else if (ev.valid && ev.record && point_ok) begin
      valid_total_next = valid_total + 1'b1;
    end else begin
      valid_total_next = valid_total;
    end
  end

  always_comb begin
    point_res              = '0;
    point_res.kind         = trpm_pkg::KIND_POINT;
    point_res.touch_id     = ev.id;
    point_res.pos_x        = mx[15:0];
    point_res.pos_y        = my[15:0];
    point_res.valid_count  = valid_total_next;
    point_res.raw_count    = ev.raw_total;

    done_res               = '0;
    done_res.kind          = trpm_pkg::KIND_DONE;
    done_res.valid_count   = valid_total_next;
    done_res.raw_count     = ev.raw_total;
    done_res.clear_status  = 1'b1;
    done_res.last          = 1'b1;

    status_res              = '0;
    status_res.kind         = ev.status_kind;
    status_res.clear_status = ev.status_clear;
    status_res.last         = 1'b1;

    res0     = status_res;
    res1     = done_res;
    push_cnt = 2'd0;
    if (ev.valid && ev.status) begin
      push_cnt = 2'd1;
    end else if (ev.valid && ev.record) begin
      if (point_ok) begin
        res0     = point_res;
        push_cnt = ev.done ? 2'd2 : 2'd1;
      end else begin
        res0     = done_res;
        push_cnt = ev.done ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_total <= '0;
    end else begin
      valid_total <= valid_total_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/trpm_fifo.sv -----
// ----------------------------------------------------------------------------
// trpm_fifo
// Result queue taking up to two results a cycle and giving one.
// ----------------------------------------------------------------------------
`default_nettype none

module trpm_fifo #(
  parameter int DEPTH = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [1:0]             push_cnt,
  input  wire trpm_pkg::res_t         din0,
  input  wire trpm_pkg::res_t         din1,
  input  wire logic                   pop,
  output trpm_pkg::res_t              dout,
  output logic [$clog2(DEPTH):0]      count
);

  localparam int AW = $clog2(DEPTH);

  trpm_pkg::res_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr, wptr_inc;

  assign wptr_inc = wptr + 1'b1;
  assign dout     = mem[rptr];

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wptr] <= din0;
    end
    if (push_cnt == 2'd2) begin
      mem[wptr_inc] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(push_cnt);
      rptr  <= rptr + AW'(pop);
      count <= count + (AW+1)'(push_cnt) - (AW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_touch_report_parse_and_map.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_touch_report_parse_and_map
// Self-checking bench for the touch report parser and mapper. A queue-fed
// driver sends status bytes and point records, a predictor tracks the frame
// parse and the coordinate mapping, and a monitor compares every result
// field with the oldest expected one. Several mapping settings are applied
// between phases, including zero and full-scale spans and areas.
// ----------------------------------------------------------------------------

module tb_touch_report_parse_and_map;

  localparam int REC_LEN     = 8;
  localparam int MAX_PTS     = 5;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_CAP   = 60;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } feed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;

  touch_report_parse_and_map dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bench state
  feed_t           byte_feed[$];
  trpm_pkg::res_t  due_reports[$];
  int    err_count = 0;
  int    cycle_count = 0;
  bit    byte_taken = 1'b0;
  bit    res_taken = 1'b0;
  bit    tx_idle_on = 1'b1;
  bit    rx_idle_on = 1'b1;
  bit    hold_arm = 1'b0;
  bit    hold_rx = 1'b0;
  int    tx_gap = 0;
  int    rx_wait = 0;
  int    fed_bytes = 0;

  // predictor copy of the mapping registers and the parse state
  trpm_pkg::cfg_t map_cfg;
  bit          awaiting_status;
  logic [3:0]  recs_left;
  int          rec_pos;
  logic [7:0]  rec_id;
  logic [15:0] rec_x, rec_y;
  logic [2:0]  pts_valid, pts_raw;

  task automatic report_mismatch(input string what);
    if (err_count < PRINT_CAP)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  function automatic void queue_report(input trpm_pkg::kind_t k, input logic [7:0] id,
                                       input logic [15:0] px, input logic [15:0] py,
                                       input logic [2:0] vc, input logic [2:0] rc,
                                       input logic clr, input logic lst);
    trpm_pkg::res_t r;
    r.kind         = k;
    r.touch_id     = id;
    r.pos_x        = px;
    r.pos_y        = py;
    r.valid_count  = vc;
    r.raw_count    = rc;
    r.clear_status = clr;
    r.last         = lst;
    due_reports.push_back(r);
  endfunction

  // swap, inverts, then rotation; false when the point leaves the area
  function automatic bit map_to_area(input logic [15:0] rx, input logic [15:0] ry,
                                     output logic [15:0] ox, output logic [15:0] oy);
    int x, y, sx, sy, t;
    x  = int'(rx);
    y  = int'(ry);
    sx = int'(map_cfg.span_x);
    sy = int'(map_cfg.span_y);
    ox = 16'd0;
    oy = 16'd0;
    if (map_cfg.swap_xy) begin
      t = x; x = y; y = t;
      t = sx; sx = sy; sy = t;
    end
    if (map_cfg.invert_x && sx > 0) x = sx - 1 - x;
    if (map_cfg.invert_y && sy > 0) y = sy - 1 - y;
    case (map_cfg.rotation)
      2'd1: begin
        t = sy - 1 - y; y = x; x = t;
      end
      2'd2: begin
        x = sx - 1 - x; y = sy - 1 - y;
      end
      2'd3: begin
        t = sx - 1 - x; x = y; y = t;
      end
      default: ;
    endcase
    if (x < 0 || y < 0 || x >= int'(map_cfg.area_width) || y >= int'(map_cfg.area_height))
      return 1'b0;
    ox = x[15:0];
    oy = y[15:0];
    return 1'b1;
  endfunction

  task automatic parse_report_byte(input logic [7:0] b, input logic st);
    logic [15:0] mx, my;
    if (st) begin
      awaiting_status = 1'b1;
      recs_left = 4'd0;
      rec_pos   = 0;
      pts_valid = 3'd0;
      pts_raw   = 3'd0;
      if (!b[trpm_pkg::STATUS_READY_BIT])
        queue_report(trpm_pkg::KIND_NOT_READY, 8'd0, 16'd0, 16'd0, 3'd0, 3'd0,
                     1'b0, 1'b1);
      else if (b[3:0] == 4'd0)
        queue_report(trpm_pkg::KIND_NO_TOUCH, 8'd0, 16'd0, 16'd0, 3'd0, 3'd0,
                     1'b1, 1'b1);
      else if (b[3:0] > MAX_PTS)
        queue_report(trpm_pkg::KIND_MALFORMED, 8'd0, 16'd0, 16'd0, 3'd0, 3'd0,
                     1'b1, 1'b1);
      else begin
        awaiting_status = 1'b0;
        recs_left = b[3:0];
      end
    end else if (!awaiting_status) begin
      case (rec_pos)
        0: rec_id = b;
        1: rec_x[7:0] = b;
        2: rec_x[15:8] = b;
        3: rec_y[7:0] = b;
        4: rec_y[15:8] = b;
        default: ;
      endcase
      if (rec_pos + 1 < REC_LEN) begin
        rec_pos++;
      end else begin
        rec_pos = 0;
        pts_raw++;
        if (map_to_area(rec_x, rec_y, mx, my)) begin
          pts_valid++;
          queue_report(trpm_pkg::KIND_POINT, rec_id, mx, my, pts_valid, pts_raw,
                       1'b0, 1'b0);
        end
        if (recs_left > 0) recs_left--;
        if (recs_left == 0) begin
          queue_report(trpm_pkg::KIND_DONE, 8'd0, 16'd0, 16'd0, pts_valid, pts_raw,
                       1'b1, 1'b1);
          awaiting_status = 1'b1;
        end
      end
    end
  endtask

  // sender: predicts on each accepted byte
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      parse_report_byte(s_tdata, s_tuser);
      byte_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    feed_t item;
    bit    nv;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || byte_taken) begin
      nv = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (byte_feed.size() > 0) begin
        item = byte_feed.pop_front();
        s_tdata <= item.data;
        s_tuser <= item.start;
        nv = 1'b1;
        tx_gap = tx_idle_on ? $urandom_range(0, 19) : 0;
      end
      s_tvalid <= nv;
    end
    byte_taken = 1'b0;
  end

  // receiver and result check
  always @(posedge clk) begin
    trpm_pkg::res_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      res_taken = 1'b1;
      if (due_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", m_tuser));
      end else begin
        exp_r = due_reports.pop_front();
        if (m_tuser !== exp_r.kind)
          report_mismatch($sformatf("kind %0d, want %0d", m_tuser, exp_r.kind));
        if (m_tdata[7:0] !== exp_r.touch_id)
          report_mismatch($sformatf("touch_id %0d, want %0d", m_tdata[7:0], exp_r.touch_id));
        if (m_tdata[23:8] !== exp_r.pos_x)
          report_mismatch($sformatf("pos_x %0d, want %0d", m_tdata[23:8], exp_r.pos_x));
        if (m_tdata[39:24] !== exp_r.pos_y)
          report_mismatch($sformatf("pos_y %0d, want %0d", m_tdata[39:24], exp_r.pos_y));
        if (m_tdata[42:40] !== exp_r.valid_count)
          report_mismatch($sformatf("valid_count %0d, want %0d", m_tdata[42:40],
                                    exp_r.valid_count));
        if (m_tdata[45:43] !== exp_r.raw_count)
          report_mismatch($sformatf("raw_count %0d, want %0d", m_tdata[45:43],
                                    exp_r.raw_count));
        if (m_tdata[46] !== exp_r.clear_status)
          report_mismatch($sformatf("clear_status %0b, want %0b", m_tdata[46],
                                    exp_r.clear_status));
        if (m_tlast !== exp_r.last)
          report_mismatch($sformatf("last %0b, want %0b", m_tlast, exp_r.last));
      end
    end
  end

  always @(negedge clk) begin
    if (res_taken) rx_wait = rx_idle_on ? $urandom_range(0, 19) : 0;
    res_taken = 1'b0;
    if (rst || hold_rx) begin
      m_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // long receiver stall so the result queue fills and the input backs up
  initial begin : rx_hold_off
    wait (hold_arm);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** touch_report_parse_and_map: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      trpm_pkg::REG_ROTATION:    map_cfg.rotation    = val[1:0];
      trpm_pkg::REG_SWAP_XY:     map_cfg.swap_xy     = val[0];
      trpm_pkg::REG_INVERT_X:    map_cfg.invert_x    = val[0];
      trpm_pkg::REG_INVERT_Y:    map_cfg.invert_y    = val[0];
      trpm_pkg::REG_SPAN_X:      map_cfg.span_x      = val;
      trpm_pkg::REG_SPAN_Y:      map_cfg.span_y      = val;
      trpm_pkg::REG_AREA_WIDTH:  map_cfg.area_width  = val;
      trpm_pkg::REG_AREA_HEIGHT: map_cfg.area_height = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mapping(input logic [1:0] rot, input logic swp, input logic ix,
                             input logic iy, input logic [15:0] sx, input logic [15:0] sy,
                             input logic [15:0] aw, input logic [15:0] ah);
    write_reg(trpm_pkg::REG_ROTATION, {14'd0, rot});
    write_reg(trpm_pkg::REG_SWAP_XY, {15'd0, swp});
    write_reg(trpm_pkg::REG_INVERT_X, {15'd0, ix});
    write_reg(trpm_pkg::REG_INVERT_Y, {15'd0, iy});
    write_reg(trpm_pkg::REG_SPAN_X, sx);
    write_reg(trpm_pkg::REG_SPAN_Y, sy);
    write_reg(trpm_pkg::REG_AREA_WIDTH, aw);
    write_reg(trpm_pkg::REG_AREA_HEIGHT, ah);
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic st);
    feed_t item;
    item.data  = b;
    item.start = st;
    byte_feed.push_back(item);
    fed_bytes++;
  endfunction

  function automatic void push_record(input logic [7:0] id, input logic [15:0] x,
                                      input logic [15:0] y);
    push_byte(id, 1'b0);
    push_byte(x[7:0], 1'b0);
    push_byte(x[15:8], 1'b0);
    push_byte(y[7:0], 1'b0);
    push_byte(y[15:8], 1'b0);
    for (int i = 5; i < REC_LEN; i++) push_byte(8'($urandom), 1'b0);
  endfunction

  // raw coordinate near the edges of the span, or anywhere
  function automatic logic [15:0] pick_coord(input logic [15:0] span);
    int lim;
    lim = int'(span);
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'(lim - 1);
      2: return span;
      3: return 16'hFFFF;
      4: return 16'($urandom);
      default: return 16'($urandom_range(lim > 0 ? lim - 1 : 0, 0));
    endcase
  endfunction

  // status byte with ready set plus records; cut short when whole is clear
  function automatic void push_touch_frame(input int nrec, input bit whole);
    int keep;
    push_byte({1'b1, 3'($urandom), 4'(nrec)}, 1'b1);
    if (whole) begin
      for (int i = 0; i < nrec; i++)
        push_record(8'($urandom), pick_coord(map_cfg.span_x), pick_coord(map_cfg.span_y));
    end else begin
      keep = $urandom_range(1, nrec * REC_LEN - 1);
      for (int i = 0; i < keep; i++) push_byte(8'($urandom), 1'b0);
    end
  endfunction

  function automatic void push_random_phase(input int n_bytes, input bit full_frames);
    int stop_at, r;
    stop_at = fed_bytes + n_bytes;
    while (fed_bytes < stop_at) begin
      r = full_frames ? 0 : $urandom_range(0, 99);
      if (r < 72) begin
        push_touch_frame(full_frames ? MAX_PTS : $urandom_range(1, MAX_PTS), 1'b1);
      end else if (r < 80) begin
        push_touch_frame($urandom_range(1, MAX_PTS), 1'b0);
      end else if (r < 86) begin
        case ($urandom_range(0, 2))
          0: push_byte({1'b0, 7'($urandom)}, 1'b1);
          1: push_byte({1'b1, 3'($urandom), 4'd0}, 1'b1);
          default: push_byte({1'b1, 3'($urandom), 4'($urandom_range(MAX_PTS + 1, 15))}, 1'b1);
        endcase
      end else if (r < 94) begin
        // stray bytes between frames are not counted; the parser ignores them unless a frame was cut short
        for (int i = 0; i < $urandom_range(1, 3); i++) begin
          push_byte(8'($urandom), 1'b0);
          fed_bytes--;
        end
      end else begin
        push_byte(8'($urandom), 1'($urandom));
      end
    end
  endfunction

  task automatic drain_block();
    while (byte_feed.size() != 0 || s_tvalid) @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
    // trailing bytes may still be in the pipeline without any result
    repeat (8) @(posedge clk);
  endtask

  initial begin
    map_cfg.rotation    = 2'd0;
    map_cfg.swap_xy     = 1'b0;
    map_cfg.invert_x    = 1'b0;
    map_cfg.invert_y    = 1'b0;
    map_cfg.span_x      = trpm_pkg::SPAN_X_RESET;
    map_cfg.span_y      = trpm_pkg::SPAN_Y_RESET;
    map_cfg.area_width  = trpm_pkg::AREA_W_RESET;
    map_cfg.area_height = trpm_pkg::AREA_H_RESET;
    awaiting_status = 1'b1;
    recs_left = 4'd0;
    rec_pos   = 0;
    rec_id    = 8'd0;
    rec_x     = 16'd0;
    rec_y     = 16'd0;
    pts_valid = 3'd0;
    pts_raw   = 3'd0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: corner point, restart mid frame, status cases, stray, dropped point
    push_byte(8'h81, 1'b1);
    push_record(8'hFF, 16'd959, 16'd539);
    push_byte(8'h83, 1'b1);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h7F, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h86, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h81, 1'b1);
    push_record(8'h00, 16'd960, 16'd0);
    drain_block();

    set_mapping(2'd1, 1'b0, 1'b0, 1'b0, 16'd960, 16'd540, 16'd540, 16'd960);
    @(posedge clk);
    push_random_phase(170, 1'b0);
    drain_block();

    tx_idle_on = 1'b0;
    set_mapping(2'd2, 1'b1, 1'b1, 1'b0, 16'd540, 16'd960, 16'd960, 16'd540);
    @(posedge clk);
    push_random_phase(170, 1'b0);
    drain_block();

    // back-pressure: sender bursts while the receiver holds off
    set_mapping(2'd0, 1'b0, 1'b0, 1'b0, 16'd960, 16'd540, 16'd960, 16'd540);
    @(posedge clk);
    push_random_phase(150, 1'b1);
    hold_arm = 1'b1;
    drain_block();

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b0;
    set_mapping(2'd3, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    @(posedge clk);
    push_random_phase(140, 1'b0);
    drain_block();

    rx_idle_on = 1'b1;
    set_mapping(2'd3, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    @(posedge clk);
    push_random_phase(170, 1'b0);
    drain_block();

    set_mapping(2'd0, 1'b1, 1'b0, 1'b1, 16'd1, 16'd1, 16'd0, 16'd0);
    @(posedge clk);
    push_random_phase(80, 1'b0);
    drain_block();

    set_mapping(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)),
                16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)));
    @(posedge clk);
    push_random_phase(170, 1'b0);
    drain_block();

    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("** touch_report_parse_and_map: PASSED **");
    else
      $display("** touch_report_parse_and_map: FAILED **");
    $finish;
  end

endmodule
